>>> hw/rtl/qtch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtch_pkg
// Shared constants and helpers for the quaternion to compass heading block.
// ----------------------------------------------------------------------------
package qtch_pkg;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int QUAT_W          = 16;
  localparam int PROD_W          = 2 * QUAT_W;
  localparam int SUM_W           = PROD_W + 4;
  localparam int ZFRAC           = 16;
  localparam int SCALE_SH        = 24;
  localparam int CX_W            = SUM_W + SCALE_SH + 2;
  localparam int Z_W             = 26;
  localparam int CORDIC_STEPS    = 23;
  localparam int STEP_W          = 5;
  localparam int ANGLE_W         = 16;
  localparam int PITCH_W         = 15;
  localparam int HEAD_W          = 10;
  localparam int ROOT_W          = 32;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  localparam logic signed [Z_W-1:0] HALF_TURN_Q16 = Z_W'(180 * 65536);

  function automatic logic signed [Z_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = Z_W'(2949120);
      5'd1:    v = Z_W'(1740967);
      5'd2:    v = Z_W'(919879);
      5'd3:    v = Z_W'(466945);
      5'd4:    v = Z_W'(234379);
      5'd5:    v = Z_W'(117304);
      5'd6:    v = Z_W'(58666);
      5'd7:    v = Z_W'(29335);
      5'd8:    v = Z_W'(14668);
      5'd9:    v = Z_W'(7334);
      5'd10:   v = Z_W'(3667);
      5'd11:   v = Z_W'(1833);
      5'd12:   v = Z_W'(917);
      5'd13:   v = Z_W'(458);
      5'd14:   v = Z_W'(229);
      5'd15:   v = Z_W'(115);
      5'd16:   v = Z_W'(57);
      5'd17:   v = Z_W'(29);
      5'd18:   v = Z_W'(14);
      5'd19:   v = Z_W'(7);
      5'd20:   v = Z_W'(4);
      5'd21:   v = Z_W'(2);
      5'd22:   v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round a Q16 degree angle to the output scale and clamp to +-lim.
  function automatic logic signed [ANGLE_W-1:0] to_angle(input logic signed [Z_W-1:0] z,
                                                         input logic signed [Z_W-1:0] lim);
    logic signed [Z_W-1:0] t;
    logic signed [Z_W-1:0] r;
    t = z + Z_W'(1 << (ZFRAC - ANGLE_FRAC_BITS - 1));
    r = t >>> (ZFRAC - ANGLE_FRAC_BITS);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[ANGLE_W-1:0];
  endfunction

endpackage

>>> hw/rtl/qtch_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtch_cordic
// Iterative vectoring CORDIC: atan2(y, x) in Q16 degrees, one step a cycle.
// ----------------------------------------------------------------------------
module qtch_cordic (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [qtch_pkg::SUM_W-1:0]     x_in,
  input  logic signed [qtch_pkg::SUM_W-1:0]     y_in,
  output logic                                  done,
  output logic signed [qtch_pkg::Z_W-1:0]       z_out
);

  logic                                 busy_r;
  logic                                 done_r;
  logic [qtch_pkg::STEP_W-1:0]          step_r;
  logic signed [qtch_pkg::CX_W-1:0]     x_r;
  logic signed [qtch_pkg::CX_W-1:0]     y_r;
  logic signed [qtch_pkg::Z_W-1:0]      z_r;
  logic signed [qtch_pkg::SUM_W-1:0]    xs;
  logic signed [qtch_pkg::SUM_W-1:0]    ys;
  logic signed [qtch_pkg::CX_W-1:0]     dx;
  logic signed [qtch_pkg::CX_W-1:0]     dy;
  logic signed [qtch_pkg::Z_W-1:0]      ang;

  assign xs  = x_in[qtch_pkg::SUM_W-1] ? -x_in : x_in;
  assign ys  = x_in[qtch_pkg::SUM_W-1] ? -y_in : y_in;
  assign dx  = y_r >>> step_r;
  assign dy  = x_r >>> step_r;
  assign ang = qtch_pkg::atan_q16(step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        step_r <= '0;
        if (x_in == '0 && y_in == '0) begin
          z_r    <= '0;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          busy_r <= 1'b1;
          x_r    <= {{2{xs[qtch_pkg::SUM_W-1]}}, xs, {qtch_pkg::SCALE_SH{1'b0}}};
          y_r    <= {{2{ys[qtch_pkg::SUM_W-1]}}, ys, {qtch_pkg::SCALE_SH{1'b0}}};
          if (x_in[qtch_pkg::SUM_W-1]) begin
            z_r <= y_in[qtch_pkg::SUM_W-1] ? -qtch_pkg::HALF_TURN_Q16
                                           : qtch_pkg::HALF_TURN_Q16;
          end else begin
            z_r <= '0;
          end
        end
      end else if (busy_r) begin
        if (!y_r[qtch_pkg::CX_W-1]) begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + ang;
        end else begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - ang;
        end
        if (step_r == qtch_pkg::STEP_W'(qtch_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign z_out = z_r;

endmodule

>>> hw/rtl/qtch_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtch_root
// floor(sqrt(a * b)) with a shift-add multiply and a bitwise square root,
// both on 64-bit working registers.
// ----------------------------------------------------------------------------
module qtch_root (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [qtch_pkg::ROOT_W-1:0]    a_in,
  input  logic [qtch_pkg::ROOT_W:0]      b_in,
  output logic                           done,
  output logic [qtch_pkg::ROOT_W-1:0]    root
);

  localparam int W = 2 * qtch_pkg::ROOT_W;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_SQRT = 2'd2;

  logic [1:0]                    phase_r;
  logic                          done_r;
  logic [5:0]                    cnt_r;
  logic [W-1:0]                  mc_r;
  logic [qtch_pkg::ROOT_W:0]     mp_r;
  logic [W-1:0]                  acc_r;
  logic [W-1:0]                  rr_r;
  logic [W-1:0]                  bit_r;
  logic [W-1:0]                  trial;

  assign trial = rr_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (phase_r)
        P_IDLE: begin
          if (start) begin
            mc_r    <= W'(a_in);
            mp_r    <= b_in;
            acc_r   <= '0;
            cnt_r   <= '0;
            phase_r <= P_MUL;
          end
        end
        P_MUL: begin
          if (mp_r[0]) acc_r <= acc_r + mc_r;
          mc_r <= mc_r << 1;
          mp_r <= mp_r >> 1;
          if (cnt_r == 6'(qtch_pkg::ROOT_W)) begin
            cnt_r   <= '0;
            rr_r    <= '0;
            bit_r   <= W'(1) << (W - 2);
            phase_r <= P_SQRT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        P_SQRT: begin
          if (acc_r >= trial) begin
            acc_r <= acc_r - trial;
            rr_r  <= (rr_r >> 1) + bit_r;
          end else begin
            rr_r <= rr_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (cnt_r == 6'(qtch_pkg::ROOT_W - 1)) begin
            done_r  <= 1'b1;
            phase_r <= P_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: phase_r <= P_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign root = rr_r[qtch_pkg::ROOT_W-1:0];

endmodule

>>> hw/rtl/quaternion_to_compass_heading.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_compass_heading
// Converts orientation quaternions to yaw, pitch, roll and a whole degree
// compass heading with an offset.
// ----------------------------------------------------------------------------
// Channel  Ports                      Direction  Contents
// in       in_tvalid/tready/tdata/    sink       quaternion, report flag, kind
//          in_tuser
// out      out_tvalid/tready/tdata    source     yaw, pitch, roll, heading
// cfg      cfg_wr_en/cfg_wr_data      sink       heading offset in degrees
//
// A fresh report takes 10 multiplies on one 16x16 multiplier and yaw and roll
// runs on one shared CORDIC unit; unless the quaternion is zero or pitch
// saturates, a root unit multiply and square root and a pitch CORDIC run follow.
// Items without a fresh report of a known kind go straight to the output state.
// in_tready is high only while the sequencer is idle; one output register
// holds the result while the next transaction is accepted.
// Reset is synchronous, active low, and clears stored angles and offset.
// ----------------------------------------------------------------------------
module quaternion_to_compass_heading (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] quat_real, [31:16] quat_i, [47:32] quat_j, [63:48] quat_k
  input  logic [63:0] in_tdata,
  // [0] new_report, [2:1] report_kind
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] yaw_angle, [30:16] pitch_angle, [46:31] roll_angle,
  // [56:47] shown_heading, [63:57] zero
  output logic [63:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data
);

  localparam int QW = qtch_pkg::QUAT_W;
  localparam int PW = qtch_pkg::PROD_W;
  localparam int SW = qtch_pkg::SUM_W;
  localparam int AW = qtch_pkg::ANGLE_W;
  localparam int HW = qtch_pkg::HEAD_W;
  localparam int RW = qtch_pkg::ROOT_W;
  localparam int NPROD = 10;
  localparam int NORTH_W = AW + 1;
  localparam int WHOLE_W = NORTH_W - qtch_pkg::ANGLE_FRAC_BITS;
  localparam int HS_W = HW + 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL     = 4'd1;
  localparam logic [3:0] S_SUM     = 4'd2;
  localparam logic [3:0] S_YAW_GO  = 4'd3;
  localparam logic [3:0] S_YAW     = 4'd4;
  localparam logic [3:0] S_ROLL_GO = 4'd5;
  localparam logic [3:0] S_ROLL    = 4'd6;
  localparam logic [3:0] S_PCHK    = 4'd7;
  localparam logic [3:0] S_ROOT    = 4'd8;
  localparam logic [3:0] S_PIT_GO  = 4'd9;
  localparam logic [3:0] S_PIT     = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  localparam logic signed [qtch_pkg::Z_W-1:0] LIM_180 =
    qtch_pkg::Z_W'(180 << qtch_pkg::ANGLE_FRAC_BITS);
  localparam logic signed [qtch_pkg::Z_W-1:0] LIM_90 =
    qtch_pkg::Z_W'(90 << qtch_pkg::ANGLE_FRAC_BITS);
  localparam logic signed [qtch_pkg::PITCH_W-1:0] PITCH_MAX =
    qtch_pkg::PITCH_W'(90 << qtch_pkg::ANGLE_FRAC_BITS);

  logic [3:0]                     state_r;
  logic [3:0]                     cnt_r;
  logic signed [QW-1:0]           qr_r, qi_r, qj_r, qk_r;
  logic signed [PW-1:0]           prod_r [NPROD];
  logic signed [QW-1:0]           ma, mb;
  logic signed [SW-1:0]           yx_r, yy_r, rx_r, ry_r, d_r, n_r;
  logic signed [AW-1:0]           yaw_r, roll_r;
  logic signed [qtch_pkg::PITCH_W-1:0] pitch_r;
  logic signed [HW-1:0]           offset_r;
  logic                           out_tvalid_r;
  logic [63:0]                    out_tdata_r;
  logic                           in_fire;

  logic                           cd_start, cd_done;
  logic signed [SW-1:0]           cd_x, cd_y;
  logic signed [qtch_pkg::Z_W-1:0] cd_z;
  logic                           rt_start, rt_done;
  logic [RW-1:0]                  rt_root;

  logic signed [SW-1:0]           dh, nh, an;
  logic signed [SW-1:0]           s_si, s_sj, s_sk, s_sr;
  logic [NORTH_W-1:0]             north;
  logic [WHOLE_W-1:0]             whole;
  logic signed [HS_W+1:0]         hsum;
  logic signed [HS_W+1:0]         hmod;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    case (cnt_r)
      4'd0:    begin ma = qi_r; mb = qi_r; end
      4'd1:    begin ma = qj_r; mb = qj_r; end
      4'd2:    begin ma = qk_r; mb = qk_r; end
      4'd3:    begin ma = qr_r; mb = qr_r; end
      4'd4:    begin ma = qi_r; mb = qj_r; end
      4'd5:    begin ma = qk_r; mb = qr_r; end
      4'd6:    begin ma = qj_r; mb = qk_r; end
      4'd7:    begin ma = qi_r; mb = qr_r; end
      4'd8:    begin ma = qi_r; mb = qk_r; end
      4'd9:    begin ma = qj_r; mb = qr_r; end
      default: begin ma = '0;   mb = '0;   end
    endcase
  end

  assign s_si = SW'(prod_r[0]);
  assign s_sj = SW'(prod_r[1]);
  assign s_sk = SW'(prod_r[2]);
  assign s_sr = SW'(prod_r[3]);

  assign dh = d_r[PW] ? (d_r >>> 1) : d_r;
  assign nh = d_r[PW] ? (n_r >>> 1) : n_r;
  assign an = nh[SW-1] ? -nh : nh;

  always_comb begin
    case (state_r)
      S_YAW_GO: begin cd_x = yx_r; cd_y = yy_r; end
      S_ROLL_GO: begin cd_x = rx_r; cd_y = ry_r; end
      default: begin cd_x = SW'(rt_root); cd_y = nh; end
    endcase
  end

  assign cd_start = (state_r == S_YAW_GO) || (state_r == S_ROLL_GO) || (state_r == S_PIT_GO);
  assign rt_start = (state_r == S_PCHK) && (d_r != '0) && (an < dh);

  qtch_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cd_start),
    .x_in  (cd_x),
    .y_in  (cd_y),
    .done  (cd_done),
    .z_out (cd_z)
  );

  qtch_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rt_start),
    .a_in  (RW'(dh - an)),
    .b_in  ((RW + 1)'(dh + an)),
    .done  (rt_done),
    .root  (rt_root)
  );

  assign north = yaw_r[AW-1]
               ? NORTH_W'(yaw_r) + NORTH_W'(360 << qtch_pkg::ANGLE_FRAC_BITS)
               : NORTH_W'(yaw_r);
  assign whole = north[NORTH_W-1:qtch_pkg::ANGLE_FRAC_BITS];
  assign hsum  = (HS_W + 2)'($signed({1'b0, whole})) + (HS_W + 2)'(offset_r);

  always_comb begin
    if (hsum >= (HS_W + 2)'(720)) begin
      hmod = hsum - (HS_W + 2)'(720);
    end else if (hsum >= (HS_W + 2)'(360)) begin
      hmod = hsum - (HS_W + 2)'(360);
    end else if (hsum <= -(HS_W + 2)'(360)) begin
      hmod = hsum + (HS_W + 2)'(360);
    end else begin
      hmod = hsum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_wr_en) begin
      offset_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (S_MUL == state_r) begin
      prod_r[cnt_r] <= ma * mb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      yaw_r        <= '0;
      pitch_r      <= '0;
      roll_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_DONE) out_tvalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            qr_r <= in_tdata[15:0];
            qi_r <= in_tdata[31:16];
            qj_r <= in_tdata[47:32];
            qk_r <= in_tdata[63:48];
            cnt_r <= '0;
            if (in_tuser[0] && in_tuser[2:1] != qtch_pkg::KIND_UNKNOWN) begin
              state_r <= S_MUL;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_MUL: begin
          if (cnt_r == 4'(NPROD - 1)) begin
            state_r <= S_SUM;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_SUM: begin
          yx_r <= s_si - s_sj - s_sk + s_sr;
          yy_r <= (SW'(prod_r[4]) + SW'(prod_r[5])) <<< 1;
          rx_r <= s_sk + s_sr - s_si - s_sj;
          ry_r <= (SW'(prod_r[6]) + SW'(prod_r[7])) <<< 1;
          d_r  <= s_si + s_sj + s_sk + s_sr;
          n_r  <= (SW'(prod_r[9]) - SW'(prod_r[8])) <<< 1;
          state_r <= S_YAW_GO;
        end
        S_YAW_GO:  state_r <= S_YAW;
        S_YAW: begin
          if (cd_done) begin
            yaw_r   <= qtch_pkg::to_angle(cd_z, LIM_180);
            state_r <= S_ROLL_GO;
          end
        end
        S_ROLL_GO: state_r <= S_ROLL;
        S_ROLL: begin
          if (cd_done) begin
            roll_r  <= qtch_pkg::to_angle(cd_z, LIM_180);
            state_r <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (d_r == '0) begin
            pitch_r <= '0;
            state_r <= S_DONE;
          end else if (an >= dh) begin
            pitch_r <= nh[SW-1] ? -PITCH_MAX : PITCH_MAX;
            state_r <= S_DONE;
          end else begin
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (rt_done) state_r <= S_PIT_GO;
        end
        S_PIT_GO:  state_r <= S_PIT;
        S_PIT: begin
          if (cd_done) begin
            pitch_r <= qtch_pkg::PITCH_W'(qtch_pkg::to_angle(cd_z, LIM_90));
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {7'd0, HW'(hmod), roll_r, pitch_r, yaw_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted while a transaction is in flight");

  a_cordic_owner: assert property (@(posedge clk) disable iff (!rst_n)
    cd_done |-> (state_r == S_YAW || state_r == S_ROLL || state_r == S_PIT))
    else $error("CORDIC finished outside an angle state");

  a_root_owner: assert property (@(posedge clk) disable iff (!rst_n)
    rt_done |-> state_r == S_ROOT)
    else $error("root unit finished outside its state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_tvalid_r && !out_tready) |=> state_r == S_DONE)
    else $error("pending result overwritten");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    pitch_r <= PITCH_MAX && pitch_r >= -PITCH_MAX)
    else $error("pitch out of range");

endmodule

>>> test/quaternion_to_compass_heading_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_compass_heading_tb
// Drives orientation reports into the heading block and compares each output
// transaction with a bit-accurate integer CORDIC predictor. Covers extreme and
// degenerate quaternions, every report kind, several heading offsets, random
// unit and raw quaternions, random idling on both sides and backpressure.
// ----------------------------------------------------------------------------
module quaternion_to_compass_heading_tb;

  typedef struct packed {
    logic signed [9:0]  heading;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  localparam logic [1:0] KIND_ROT  = 2'd0;
  localparam logic [1:0] KIND_GAME = 2'd1;
  localparam logic [1:0] KIND_GYRO = 2'd2;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int HOLD_CYCLES    = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [9:0]  cfg_wr_data = '0;

  always #5 clk = ~clk;

  quaternion_to_compass_heading dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  longint  offset_deg;
  longint  yaw_st, pitch_st, roll_st;
  angles_t expected_angles[$];
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_requests = 0;
  int      hold_served = 0;
  int      hold_off = 0;
  int      idle_cycles = 0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_table(int i);
    longint t[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                      29, 14, 7, 4, 2, 1};
    return t[i];
  endfunction

  function automatic longint atan2_q16(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    x = x * 16777216;
    y = y * 16777216;
    for (int i = 0; i < qtch_pkg::CORDIC_STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_table(i);
      end else begin
        x -= dx; y += dy; z -= atan_table(i);
      end
    end
    return z;
  endfunction

  function automatic longint round_clamp(longint z, longint lim);
    longint r, l;
    r = floor_shift(z + (1 << (qtch_pkg::ZFRAC - qtch_pkg::ANGLE_FRAC_BITS - 1)),
                    qtch_pkg::ZFRAC - qtch_pkg::ANGLE_FRAC_BITS);
    l = lim << qtch_pkg::ANGLE_FRAC_BITS;
    if (r > l) r = l;
    if (r < -l) r = -l;
    return r;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic void update_orientation(longint qr, longint qi, longint qj, longint qk);
    longint sr, si, sj, sk, d, n, an, s;
    sr = qr * qr; si = qi * qi; sj = qj * qj; sk = qk * qk;
    d = si + sj + sk + sr;
    n = -2 * (qi * qk - qj * qr);
    yaw_st  = round_clamp(atan2_q16(2 * (qi * qj + qk * qr), si - sj - sk + sr), 180);
    roll_st = round_clamp(atan2_q16(2 * (qj * qk + qi * qr), -si - sj + sk + sr), 180);
    if (d == 0) begin
      pitch_st = 0;
      return;
    end
    if (d > 64'hFFFF_FFFF) begin
      d = d / 2;
      n = n / 2;
    end
    an = (n < 0) ? -n : n;
    if (an >= d) pitch_st = (n > 0) ? (90 << qtch_pkg::ANGLE_FRAC_BITS)
                                    : -(90 << qtch_pkg::ANGLE_FRAC_BITS);
    else begin
      s = int_sqrt((d - an) * (d + an));
      pitch_st = round_clamp(atan2_q16(n, s), 90);
    end
  endfunction

  function automatic angles_t predict_heading(logic [63:0] q, logic [2:0] u);
    angles_t a;
    longint north;
    if (u[0] && u[2:1] != qtch_pkg::KIND_UNKNOWN)
      update_orientation(longint'($signed(q[15:0])), longint'($signed(q[31:16])),
                         longint'($signed(q[47:32])), longint'($signed(q[63:48])));
    north = yaw_st;
    if (north < 0) north += 360 << qtch_pkg::ANGLE_FRAC_BITS;
    if (north < 0) north = 0;
    a.yaw     = yaw_st[15:0];
    a.pitch   = pitch_st[14:0];
    a.roll    = roll_st[15:0];
    a.heading = 10'(((north >>> qtch_pkg::ANGLE_FRAC_BITS) + offset_deg) % 360);
    return a;
  endfunction

  task automatic send_report(logic [63:0] q, logic [2:0] u);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= q;
    in_tuser  <= u;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_angles.push_back(predict_heading(q, u));
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_quat(int r, int i, int j, int k, logic [1:0] kind, logic fresh);
    send_report({16'(k), 16'(j), 16'(i), 16'(r)}, {kind, fresh});
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(int deg);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 10'(deg);
    offset_deg = longint'($signed(10'(deg)));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random unit-ish quaternion with random signs, or raw noise.
  task automatic send_random();
    int c[4];
    logic [2:0] u;
    u = {$urandom_range(3, 0) == 3 ? qtch_pkg::KIND_UNKNOWN : 2'($urandom_range(2, 0)),
         1'($urandom_range(9, 0) != 0)};
    if ($urandom_range(3, 0) == 0) send_report({$urandom, $urandom}, u);
    else begin
      for (int n = 0; n < 4; n++) c[n] = $urandom_range(16384, 0);
      for (int n = 0; n < 4; n++) if ($urandom_range(1, 0)) c[n] = -c[n];
      if ($urandom_range(7, 0) == 0) c[$urandom_range(3, 0)] = 0;
      send_quat(c[0], c[1], c[2], c[3], u[2:1], u[0]);
    end
  endtask

  task automatic test_directed();
    send_quat(0, 0, 0, 0, KIND_ROT, 1'b1);
    send_quat(16384, 0, 0, 0, KIND_ROT, 1'b1);
    send_quat(0, 0, 0, 16384, KIND_GAME, 1'b1);
    send_quat(11585, 0, 0, 11585, KIND_GYRO, 1'b1);
    send_quat(11585, 0, 0, -11585, KIND_ROT, 1'b1);
    send_quat(11585, 0, 11585, 0, KIND_ROT, 1'b1);
    send_quat(11585, 0, -11585, 0, KIND_ROT, 1'b1);
    send_quat(32767, 32767, 32767, 32767, KIND_ROT, 1'b1);
    send_quat(-32768, -32768, -32768, -32768, KIND_GAME, 1'b1);
    send_quat(-32768, 32767, -32768, 32767, KIND_GYRO, 1'b1);
    send_quat(0, 16384, 0, 0, KIND_ROT, 1'b1);
    send_quat(-16384, 0, 0, 1, KIND_ROT, 1'b1);
    send_quat(-16384, 0, 0, -1, KIND_ROT, 1'b1);
    send_quat(1, 2, 3, 4, qtch_pkg::KIND_UNKNOWN, 1'b1);
    send_quat(100, 200, 300, 400, KIND_ROT, 1'b0);
    send_quat(0, 0, 0, 0, qtch_pkg::KIND_UNKNOWN, 1'b0);
    send_quat(-1, -1, -1, -1, KIND_ROT, 1'b1);
  endtask

  task automatic test_offsets();
    int offs[6] = '{359, -359, 180, -1, 511, -512};
    foreach (offs[n]) begin
      write_offset(offs[n]);
      send_quat(11585, 0, 0, -11585, KIND_ROT, 1'b1);
      send_quat(16384, 0, 0, 0, KIND_ROT, 1'b1);
      send_random();
    end
  endtask

  task automatic test_random(int count, int s_idle, int r_idle, int deg);
    write_offset(deg);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (count) send_random();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = hold_requests + 1;
    repeat (12) send_random();
    wait_drained();
    repeat (6) send_random();
  endtask

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_off <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else out_tready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
  end

  always @(posedge clk) begin
    angles_t got, exp_a;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[56:0];
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %h", out_tdata);
      end else begin
        exp_a = expected_angles.pop_front();
        if (got !== exp_a || out_tdata[63:57] !== 7'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch yaw %0d/%0d pitch %0d/%0d roll %0d/%0d head %0d/%0d",
                     exp_a.yaw, got.yaw, exp_a.pitch, got.pitch, exp_a.roll, got.roll,
                     exp_a.heading, got.heading);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_off > 0)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    offset_deg = 0;
    yaw_st = 0; pitch_st = 0; roll_st = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    recv_idle_pct = 10;
    test_directed();
    test_offsets();
    test_random(180, 30, 51, 90);
    test_random(180, 51, 30, -270);
    test_random(160, 0, 0, 0);
    test_backpressure();
    wait_drained();
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
